### src/lwes_pkg.sv
package lwes_pkg;

  localparam int unsigned WinDepth = 1024;
  localparam int unsigned AddrW    = $clog2(WinDepth);
  localparam int unsigned CountW   = $clog2(WinDepth + 1);
  localparam int unsigned CostW    = 16;
  localparam int unsigned TargetW  = 24;
  localparam int unsigned SumW     = 27;
  localparam int unsigned BestW    = 11;
  localparam int unsigned CmpW     = (CountW > BestW) ? CountW : BestW;

  localparam logic [BestW-1:0] BestMax = '1;

  typedef struct packed {
    logic [CostW-1:0] island_cost;
    logic             last_element;
  } in_t;

  typedef struct packed {
    logic [BestW-1:0] best_length;
    logic             overflow;
  } out_t;

  typedef struct packed {
    logic valid;
    out_t data;
  } res_t;

endpackage

### src/lwes_ram.sv
module lwes_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/lwes_seq.sv
module lwes_seq import lwes_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  in_t                in_data_i,
  output logic               in_stall_o,
  input  logic [TargetW-1:0] target_i,
  input  logic               res_free_i,
  output res_t               res_o,
  output logic               ram_we_o,
  output logic [AddrW-1:0]   ram_waddr_o,
  output logic [CostW-1:0]   ram_wdata_o,
  output logic [AddrW-1:0]   ram_raddr_o,
  input  logic [CostW-1:0]   ram_rdata_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVICT,
    S_CHECK,
    S_DROP
  } state_e;

  state_e             state_q, state_d;
  logic [AddrW-1:0]   head_q, head_d;
  logic [CountW-1:0]  count_q, count_d;
  logic [SumW-1:0]    sum_q, sum_d;
  logic [BestW-1:0]   best_q, best_d;
  logic               ovf_q, ovf_d;
  logic [CostW-1:0]   cost_q, cost_d;
  logic               last_q, last_d;

  logic               full;
  logic [AddrW:0]     tail_sum;
  logic [AddrW-1:0]   tail;
  logic [AddrW-1:0]   head_inc;
  logic [SumW-1:0]    add_op, sub_op, sum_calc;
  logic [SumW-1:0]    target_x;
  logic               drop_req;
  logic               hit;
  logic [CmpW-1:0]    cnt_x, best_x;
  logic [BestW-1:0]   best_new;

  assign full     = (count_q == CountW'(WinDepth));
  assign tail_sum = (AddrW+1)'(head_q) + (AddrW+1)'(count_q[AddrW-1:0]);
  assign tail     = (tail_sum >= (AddrW+1)'(WinDepth))
                    ? AddrW'(tail_sum - (AddrW+1)'(WinDepth)) : AddrW'(tail_sum);
  assign head_inc = (head_q == AddrW'(WinDepth - 1)) ? '0 : head_q + AddrW'(1);

  assign sum_calc = sum_q + add_op - sub_op;

  assign target_x = SumW'(target_i);
  assign drop_req = (count_q != '0) && (sum_q > target_x);
  assign cnt_x    = CmpW'(count_q);
  assign best_x   = CmpW'(best_q);
  assign hit      = (sum_q == target_x) && (cnt_x > best_x);
  assign best_new = !hit ? best_q
                  : (cnt_x > CmpW'(BestMax)) ? BestMax : BestW'(cnt_x);

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    sum_d       = sum_q;
    best_d      = best_q;
    ovf_d       = ovf_q;
    cost_d      = cost_q;
    last_d      = last_q;
    add_op      = '0;
    sub_op      = '0;
    ram_we_o    = 1'b0;
    ram_waddr_o = tail;
    ram_wdata_o = in_data_i.island_cost;
    ram_raddr_o = head_q;
    res_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cost_d = in_data_i.island_cost;
          last_d = in_data_i.last_element;
          if (full) begin
            state_d = S_EVICT;
          end else begin
            ram_we_o = 1'b1;
            add_op   = SumW'(in_data_i.island_cost);
            sum_d    = sum_calc;
            count_d  = count_q + CountW'(1);
            state_d  = S_CHECK;
          end
        end
      end
      S_EVICT: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = head_q;
        ram_wdata_o = cost_q;
        add_op      = SumW'(cost_q);
        sub_op      = SumW'(ram_rdata_i);
        sum_d       = sum_calc;
        head_d      = head_inc;
        ovf_d       = 1'b1;
        state_d     = S_CHECK;
      end
      S_CHECK: begin
        if (drop_req) begin
          state_d = S_DROP;
        end else begin
          best_d = best_new;
          if (!last_q) begin
            state_d = S_IDLE;
          end else if (res_free_i) begin
            res_o.valid            = 1'b1;
            res_o.data.best_length = best_new;
            res_o.data.overflow    = ovf_q;
            head_d  = '0;
            count_d = '0;
            sum_d   = '0;
            best_d  = '0;
            ovf_d   = 1'b0;
            state_d = S_IDLE;
          end
        end
      end
      S_DROP: begin
        sub_op  = SumW'(ram_rdata_i);
        sum_d   = sum_calc;
        head_d  = head_inc;
        count_d = count_q - CountW'(1);
        state_d = S_CHECK;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      count_q <= '0;
      sum_q   <= '0;
      best_q  <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      sum_q   <= sum_d;
      best_q  <= best_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cost_q <= cost_d;
    last_q <= last_d;
  end

endmodule

### src/longest_window_exact_sum.sv
// Channel  | Direction | Payload | Transfer when
// ---------+-----------+---------+-------------------------------
// cfg      | in        | target  | cfg_we_i
// in       | in        | in_t    | in_valid_i && !in_stall_o
// out      | out       | out_t   | out_valid_o && !out_stall_i
//
// Steps: an item goes from idle to check; each entry dropped from the window
// head adds a drop step and a full window adds an evict step, set by the
// registered read of the window RAM feeding the one shared add/subtract unit.
// Reset: clears window pointers, sum, best length, overflow and target; the RAM
// is not cleared and needs no sweep.
// Stalls: a result waits in the output register while the next item is taken;
// a last item holds in the check step until that register is free.
module longest_window_exact_sum import lwes_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [TargetW-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_t               out_data_o
);

  logic [TargetW-1:0] target_q;
  logic               out_valid_q;
  out_t               out_data_q;
  res_t               res;
  logic               res_free;

  logic               ram_we;
  logic [AddrW-1:0]   ram_waddr;
  logic [CostW-1:0]   ram_wdata;
  logic [AddrW-1:0]   ram_raddr;
  logic [CostW-1:0]   ram_rdata;

  assign res_free = !out_valid_q || !out_stall_i;

  lwes_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .target_i    (target_q),
    .res_free_i  (res_free),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  lwes_ram #(
    .Width (CostW),
    .Depth (WinDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        target_q <= cfg_wdata_i;
      end
      if (res.valid) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      out_data_q <= res.data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### src/lwes_checker.sv
module lwes_checker import lwes_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while item in progress");

  a_result_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("result issued before item finished");

  a_best_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(out_data_o.best_length) <= WinDepth)
    else $error("best length exceeds window depth");

endmodule

bind longest_window_exact_sum lwes_checker u_chk (.*);
